@@ hw/rtl/lpht_pkg.sv @@
// shared constants for the linear probing hash table unit
// command codes, register width and default parameter values; no dependencies
package lpht_pkg;

  localparam int unsigned DEF_CAPACITY   = 1024;
  localparam int unsigned DEF_KEY_WIDTH  = 32;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // size register: 4 bits, active log2 saturates to 1..10
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned SIZE_MIN   = 1;
  localparam int unsigned SIZE_MAX   = 10;
  localparam int unsigned SIZE_RESET = 4;

  localparam int unsigned CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

endpackage

@@ hw/rtl/linear_probe_hash_table_unit.sv @@
// A refused add (table full) or an unused command goes from idle straight to the push
// state; else k slots are probed, k (1 .. active length), one memory read per cycle,
// then the push state. One word is worked on at a time; in_stall_o is high outside idle.
// Reset: async, active low; then a clearing pass of one slot per cycle over the whole
// slot memory (1024 slots at default capacity) during which in_stall_o stays high.
module linear_probe_hash_table_unit #(
  parameter int unsigned CAPACITY   = lpht_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_WIDTH  = lpht_pkg::DEF_KEY_WIDTH,
  parameter int unsigned DATA_WIDTH = lpht_pkg::DEF_DATA_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpht_pkg::SIZE_W-1:0]    cfg_data_i,
  // command words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lpht_pkg::CMD_W-1:0]     command_i,
  input  logic [KEY_WIDTH-1:0]           key_i,
  input  logic [DATA_WIDTH-1:0]          data_in_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           success_o,
  output logic                           table_full_o,
  output logic [DATA_WIDTH-1:0]          data_out_o
);

  localparam int unsigned CAP_LOG2  = $clog2(CAPACITY + 1) - 1;
  localparam int unsigned IDX_W     = (CAP_LOG2 < lpht_pkg::SIZE_MAX) ? CAP_LOG2
                                                                      : lpht_pkg::SIZE_MAX;
  localparam int unsigned MEM_DEPTH = 1 << IDX_W;
  localparam int unsigned CNT_W     = IDX_W + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  typedef struct packed {
    logic                  occ;
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] value;
  } slot_t;

  slot_t mem [MEM_DEPTH];
  slot_t rd_q;

  logic [1:0]                    state_q, state_d;
  logic [lpht_pkg::SIZE_W-1:0]   size_q;
  logic [IDX_W-1:0]              clr_q, clr_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              off_q, off_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [lpht_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0]          key_q, key_d;
  logic [DATA_WIDTH-1:0]         data_q, data_d;
  logic                          res_ok_q, res_ok_d;
  logic                          res_full_q, res_full_d;
  logic [DATA_WIDTH-1:0]         res_dout_q, res_dout_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_ok_q, out_full_q;
  logic [DATA_WIDTH-1:0]         out_dout_q;

  logic [lpht_pkg::SIZE_W-1:0]   size_sat, size_eff;
  logic [CNT_W-1:0]              len;
  logic [IDX_W-1:0]              mask;
  logic [IDX_W+KEY_WIDTH-1:0]    key_ext;
  logic [IDX_W-1:0]              home;
  logic                          in_acc, out_free, match;
  logic [IDX_W-1:0]              rd_addr, wr_addr;
  logic                          mem_we;
  slot_t                         wr_data;

  // active length: saturate the register, then cap at the memory depth
  always_comb begin
    size_sat = size_q;
    if (size_q < lpht_pkg::SIZE_W'(lpht_pkg::SIZE_MIN)) size_sat = lpht_pkg::SIZE_W'(lpht_pkg::SIZE_MIN);
    if (size_q > lpht_pkg::SIZE_W'(lpht_pkg::SIZE_MAX)) size_sat = lpht_pkg::SIZE_W'(lpht_pkg::SIZE_MAX);
    size_eff = (size_sat > lpht_pkg::SIZE_W'(IDX_W)) ? lpht_pkg::SIZE_W'(IDX_W) : size_sat;
  end

  assign len     = CNT_W'(1) << size_eff;
  assign mask    = IDX_W'(len - CNT_W'(1));
  assign key_ext = {{IDX_W{1'b0}}, key_i};
  assign home    = key_ext[IDX_W-1:0] & mask;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign match       = rd_q.occ && (rd_q.key == key_q);

  assign out_valid_o  = out_valid_q;
  assign success_o    = out_ok_q;
  assign table_full_o = out_full_q;
  assign data_out_o   = out_dout_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    off_d       = off_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    data_d      = data_q;
    res_ok_d    = res_ok_q;
    res_full_d  = res_full_q;
    res_dout_d  = res_dout_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;
    rd_addr     = (idx_q + IDX_W'(1)) & mask;

    case (state_q)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MEM_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        rd_addr = home;
        if (in_acc) begin
          cmd_d      = command_i;
          key_d      = key_i;
          data_d     = data_in_i;
          idx_d      = home;
          off_d      = '0;
          res_ok_d   = 1'b0;
          res_full_d = 1'b0;
          res_dout_d = '0;
          case (command_i)
            lpht_pkg::CMD_ADD: begin
              if (count_q >= len) begin
                res_full_d = 1'b1;
                state_d    = ST_PUSH;
              end else begin
                state_d = ST_SCAN;
              end
            end
            lpht_pkg::CMD_REMOVE, lpht_pkg::CMD_CONTAINS: state_d = ST_SCAN;
            default: state_d = ST_PUSH;
          endcase
        end
      end
      ST_SCAN: begin
        // rd_q holds slot idx_q; the next slot is already being read
        if (cmd_q == lpht_pkg::CMD_ADD && !rd_q.occ) begin
          mem_we   = 1'b1;
          wr_data  = '{occ: 1'b1, key: key_q, value: data_q};
          count_d  = count_q + CNT_W'(1);
          res_ok_d = 1'b1;
          state_d  = ST_PUSH;
        end else if (cmd_q == lpht_pkg::CMD_ADD && match) begin
          state_d = ST_PUSH;
        end else if (cmd_q != lpht_pkg::CMD_ADD && match) begin
          res_ok_d   = 1'b1;
          res_dout_d = rd_q.value;
          if (cmd_q == lpht_pkg::CMD_REMOVE) begin
            mem_we = 1'b1;
            if (count_q != '0) count_d = count_q - CNT_W'(1);
          end
          state_d = ST_PUSH;
        end else if (off_q == len - CNT_W'(1)) begin
          state_d = ST_PUSH;
        end else begin
          off_d = off_q + CNT_W'(1);
          idx_d = (idx_q + IDX_W'(1)) & mask;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      size_q      <= lpht_pkg::SIZE_W'(lpht_pkg::SIZE_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    data_q     <= data_d;
    res_ok_q   <= res_ok_d;
    res_full_q <= res_full_d;
    res_dout_q <= res_dout_d;
    if (state_q == ST_PUSH && out_free) begin
      out_ok_q   <= res_ok_q;
      out_full_q <= res_full_q;
      out_dout_q <= res_dout_q;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE && out_valid_d == (out_valid_q && out_stall_i))
    else $error("word accepted outside idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MEM_DEPTH))
    else $error("entry count above memory depth");

  a_push_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && out_free) |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not loaded into output register");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == ST_SCAN) |-> wr_addr != rd_addr)
    else $error("scan write collides with prefetch read");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o && mem_we)
    else $error("clearing pass not exclusive");

endmodule
